FILE: hdl/sptt_pkg.sv
// Package for the sparse polynomial term table: command codes, status codes,
// sequencer states and sizing constants. No dependencies.
`timescale 1ns / 1ps
package sptt_pkg;
  localparam int TERMS_DEFAULT = 16;
  localparam int COEF_W = 32;
  localparam int EXP_W = 16;

  typedef enum logic [2:0] {
    CMD_ADD   = 3'd0,
    CMD_SUB   = 3'd1,
    CMD_MUL   = 3'd2,
    CMD_QUERY = 3'd3,
    CMD_CLEAR = 3'd4,
    CMD_SORT  = 3'd5,
    CMD_DUMP  = 3'd6,
    CMD_NONE  = 3'd7
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_OVERFLOW = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_FIND,     // scan for matching exponent (add, sub, query)
    S_MERGE,    // write back merged coefficient
    S_OVCHK,    // multiply: exponent overflow check
    S_MULT,     // multiply: one term per step through shared multiplier
    S_MULWB,    // multiply: write product back
    S_COMPACT,  // drop zero terms, one entry per cycle
    S_SORTRD,   // insertion sort: read key
    S_SORTSH,   // insertion sort: shift one entry
    S_DUMP,     // emit one term
    S_RESULT    // single result word
  } state_t;
endpackage

FILE: hdl/sparse_polynomial_term_table.sv
// Sparse polynomial term table, top level.
// Depends on sptt_pkg. Term storage is two small register arrays in this module.
`timescale 1ns / 1ps
// Holds up to TERMS (exponent, coefficient) terms with distinct exponents and
// nonzero coefficients. One command per input word: add, subtract, multiply
// by a monomial, query, clear, sort (falling exponent) and dump. Commands are
// executed by a small sequencer that walks the table entry by entry
// through its comparators, adders and one 32x32 multiplier; the block drops
// ready for the whole command. Add, subtract and query scan for the exponent;
// add and subtract then merge into a hit, with a compaction pass when the sum
// cancels, or append a new term; multiply runs an overflow-check pass, a
// multiply step and a write-back step per term, then a compaction pass; sort is
// insertion sort at one shift per cycle; dump emits one word per term as the
// output side takes them, or one result word on an empty table. Result words
// leave through an output register; last marks the final word of a command.
// No clearing pass after reset: only entries below term_count are ever read.
module sparse_polynomial_term_table #(
  parameter int TERMS = sptt_pkg::TERMS_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [2:0]                     cmd,
  input  logic signed [31:0]             term_coef,
  input  logic [15:0]                    term_exp,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic signed [31:0]             out_coef,
  output logic [15:0]                    out_exp,
  output logic [$clog2(TERMS+1)-1:0]     term_count,
  output logic [1:0]                     status,
  output logic                           last
);
  import sptt_pkg::*;

  localparam int IW = (TERMS > 1) ? $clog2(TERMS) : 1;
  localparam int CW = $clog2(TERMS + 1);

  logic [EXP_W-1:0]  exps  [TERMS];
  logic [COEF_W-1:0] coefs [TERMS];
  logic [CW-1:0]     count, count_next;

  state_t state, state_next;
  cmd_t   op;
  logic [COEF_W-1:0] arg_coef;
  logic [EXP_W-1:0]  arg_exp;
  logic [CW-1:0]     idx, wr;       // scan index, compaction write index
  logic [CW-1:0]     jdx;           // sort inner index
  logic [EXP_W-1:0]  key_exp;
  logic [COEF_W-1:0] key_coef;
  logic [COEF_W-1:0] prod;
  logic [COEF_W-1:0] query_val;

  logic [IW-1:0] ia, ja, wa, jm1;
  assign ia  = idx[IW-1:0];
  assign ja  = jdx[IW-1:0];
  assign wa  = wr[IW-1:0];
  assign jm1 = IW'(jdx - CW'(1));

  logic scan_done, hit, ovf;
  logic [COEF_W-1:0] sum;
  logic [EXP_W:0]    esum;
  assign scan_done = (idx >= count);
  assign hit       = !scan_done && (exps[ia] == arg_exp);
  assign sum       = coefs[ia] + arg_coef;
  assign esum      = {1'b0, exps[ia]} + {1'b0, arg_exp};
  assign ovf       = esum[EXP_W];

  logic out_free;
  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == S_IDLE) && out_free;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          unique case (cmd_t'(cmd))
            CMD_ADD, CMD_SUB, CMD_QUERY: state_next = S_FIND;
            CMD_MUL:   state_next = S_OVCHK;
            CMD_SORT:  state_next = S_SORTRD;
            CMD_DUMP:  state_next = (count == '0) ? S_RESULT : S_DUMP;
            default:   state_next = S_RESULT;
          endcase
        end
      end
      S_FIND: begin
        if (hit) state_next = (op == CMD_QUERY) ? S_RESULT : S_MERGE;
        else if (scan_done) state_next = S_RESULT;
      end
      S_MERGE:   state_next = (sum == '0) ? S_COMPACT : S_RESULT;
      S_OVCHK: begin
        if (scan_done) state_next = S_MULT;
        else if (ovf) state_next = S_RESULT;
      end
      S_MULT:    state_next = scan_done ? S_COMPACT : S_MULWB;
      S_MULWB:   state_next = S_MULT;
      S_COMPACT: if (scan_done) state_next = S_RESULT;
      S_SORTRD:  if (scan_done) state_next = S_RESULT;
                 else state_next = S_SORTSH;
      S_SORTSH: begin
        if (jdx == '0 || exps[jm1] >= key_exp) state_next = S_SORTRD;
      end
      S_DUMP: begin
        if (out_free && idx + CW'(1) >= count) state_next = S_IDLE;
      end
      S_RESULT:  if (out_free) state_next = S_IDLE;
      default:   state_next = S_IDLE;
    endcase
  end

  // status of the command's result
  status_t res_status;
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (out_ready) out_valid <= 1'b0;
      if ((state == S_RESULT || state == S_DUMP) && out_free) out_valid <= 1'b1;
    end
  end

  // datapath
  always_comb begin
    count_next = count;
    unique case (state)
      S_IDLE:  if (in_valid && in_ready && cmd_t'(cmd) == CMD_CLEAR) count_next = '0;
      S_FIND:  if (scan_done && op != CMD_QUERY && arg_coef != '0 && count < CW'(TERMS))
                 count_next = count + CW'(1);
      S_COMPACT: if (scan_done) count_next = wr;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          op        <= cmd_t'(cmd);
          arg_coef  <= (cmd_t'(cmd) == CMD_SUB) ? (COEF_W'(0) - term_coef) : term_coef;
          arg_exp   <= term_exp;
          idx       <= (cmd_t'(cmd) == CMD_SORT) ? CW'(1) : '0;
          wr        <= '0;
          query_val <= '0;
          res_status <= ST_OK;
        end
      end
      S_FIND: begin
        if (hit) begin
          if (op == CMD_QUERY) query_val <= coefs[ia];
        end else if (scan_done) begin
          if (op != CMD_QUERY && arg_coef != '0) begin
            if (count < CW'(TERMS)) begin
              exps[ia]  <= arg_exp;
              coefs[ia] <= arg_coef;
            end else begin
              res_status <= ST_FULL;
            end
          end
        end else begin
          idx <= idx + CW'(1);
        end
      end
      S_MERGE: begin
        coefs[ia] <= sum;
        idx <= '0;
      end
      S_OVCHK: begin
        if (scan_done) idx <= '0;
        else if (ovf) res_status <= ST_OVERFLOW;
        else idx <= idx + CW'(1);
      end
      S_MULT: begin
        if (scan_done) idx <= '0;
        else prod <= COEF_W'(coefs[ia] * arg_coef);
      end
      S_MULWB: begin
        coefs[ia] <= prod;
        exps[ia]  <= esum[EXP_W-1:0];
        idx <= idx + CW'(1);
      end
      S_COMPACT: begin
        if (!scan_done) begin
          if (coefs[ia] != '0) begin
            exps[wa]  <= exps[ia];
            coefs[wa] <= coefs[ia];
            wr <= wr + CW'(1);
          end
          idx <= idx + CW'(1);
        end
      end
      S_SORTRD: begin
        if (!scan_done) begin
          key_exp  <= exps[ia];
          key_coef <= coefs[ia];
          jdx <= idx;
        end
      end
      S_SORTSH: begin
        if (jdx == '0 || exps[jm1] >= key_exp) begin
          exps[ja]  <= key_exp;
          coefs[ja] <= key_coef;
          idx <= idx + CW'(1);
        end else begin
          exps[ja]  <= exps[jm1];
          coefs[ja] <= coefs[jm1];
          jdx <= jdx - CW'(1);
        end
      end
      S_DUMP: begin
        if (out_free) begin
          out_coef   <= coefs[ia];
          out_exp    <= exps[ia];
          term_count <= count;
          status     <= ST_OK;
          last       <= (idx + CW'(1) >= count);
          idx <= idx + CW'(1);
        end
      end
      S_RESULT: begin
        if (out_free) begin
          out_coef   <= query_val;
          out_exp    <= arg_exp;
          term_count <= count;
          status     <= res_status;
          last       <= 1'b1;
        end
      end
      default: ;
    endcase
  end

`ifndef SYNTHESIS
  a_count_max: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(TERMS)) else $error("term count above capacity");
  a_busy_ready: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !in_ready) else $error("ready while busy");
  a_clear: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && cmd_t'(cmd) == CMD_CLEAR) |=> (count == '0))
    else $error("clear did not empty table");
`endif
endmodule

FILE: bench/testbench.sv
// Testbench for sparse_polynomial_term_table: random and directed commands,
// a term-table predictor in a scoreboard class. Depends on sptt_pkg and the RTL.
`timescale 1ns / 1ps
module testbench;
  import sptt_pkg::*;

  typedef struct packed {
    logic signed [31:0] coef;
    logic [15:0]        expo;
    logic [4:0]         count;
    logic [1:0]         stat;
    logic               lst;
  } word_t;

  // Predicts the term table and holds the words it still owes.
  class term_board;
    logic [15:0] exps[16];
    logic [31:0] coefs[16];
    int          nterms;
    word_t       owed[$];
    int          errors;

    function new();
      nterms = 0;
      errors = 0;
    endfunction

    function void squeeze();
      int w;
      w = 0;
      for (int i = 0; i < nterms; i++) begin
        if (coefs[i] != 0) begin
          exps[w] = exps[i];
          coefs[w] = coefs[i];
          w++;
        end
      end
      nterms = w;
    endfunction

    function status_t merge(logic [31:0] c, logic [15:0] e);
      for (int i = 0; i < nterms; i++) begin
        if (exps[i] == e) begin
          coefs[i] = coefs[i] + c;
          if (coefs[i] == 0) squeeze();
          return ST_OK;
        end
      end
      if (c == 0) return ST_OK;
      if (nterms >= 16) return ST_FULL;
      exps[nterms] = e;
      coefs[nterms] = c;
      nterms++;
      return ST_OK;
    endfunction

    function void note_word(logic [2:0] op, logic [31:0] c, logic [15:0] e);
      status_t st;
      logic [31:0] res;
      word_t w;
      logic [15:0] te;
      logic [31:0] tc;
      int j;
      st = ST_OK;
      res = 0;
      case (cmd_t'(op))
        CMD_ADD: st = merge(c, e);
        CMD_SUB: st = merge(-c, e);
        CMD_MUL: begin
          for (int i = 0; i < nterms; i++)
            if ({1'b0, exps[i]} + {1'b0, e} > 17'hFFFF) st = ST_OVERFLOW;
          if (st == ST_OK) begin
            for (int i = 0; i < nterms; i++) begin
              exps[i] = exps[i] + e;
              coefs[i] = coefs[i] * c;
            end
            squeeze();
          end
        end
        CMD_QUERY: begin
          for (int i = 0; i < nterms; i++)
            if (exps[i] == e) begin
              res = coefs[i];
              break;
            end
        end
        CMD_CLEAR: nterms = 0;
        CMD_SORT: begin
          for (int i = 1; i < nterms; i++) begin
            te = exps[i];
            tc = coefs[i];
            j = i;
            while (j > 0 && exps[j-1] < te) begin
              exps[j] = exps[j-1];
              coefs[j] = coefs[j-1];
              j--;
            end
            exps[j] = te;
            coefs[j] = tc;
          end
        end
        CMD_DUMP: begin
          if (nterms > 0) begin
            for (int i = 0; i < nterms; i++) begin
              w = '{coefs[i], exps[i], 5'(nterms), ST_OK, i == nterms - 1};
              owed.push_back(w);
            end
            return;
          end
        end
        default: ;
      endcase
      w = '{res, e, 5'(nterms), st, 1'b1};
      owed.push_back(w);
    endfunction

    function void check_word(word_t got);
      word_t exp_w;
      if (owed.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected word %p", got);
        return;
      end
      exp_w = owed.pop_front();
      if (got !== exp_w) begin
        errors++;
        if (errors <= 10) $display("mismatch: expected %p, got %p", exp_w, got);
      end
    endfunction
  endclass

  logic        clk = 0;
  logic        rst = 1;
  logic        in_valid = 0;
  logic        in_ready;
  logic [2:0]  cmd = 0;
  logic signed [31:0] term_coef = 0;
  logic [15:0] term_exp = 0;
  logic        out_valid;
  logic        out_ready = 0;
  logic signed [31:0] out_coef;
  logic [15:0] out_exp;
  logic [4:0]  term_count;
  logic [1:0]  status;
  logic        last;

  term_board board = new();
  int send_idle = 0;   // percent chance the sender holds off a cycle
  int recv_stall = 0;  // percent chance the receiver stalls a cycle
  int cycles = 0;

  always #5 clk = ~clk;

  sparse_polynomial_term_table uut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready), .cmd(cmd),
    .term_coef(term_coef), .term_exp(term_exp), .out_valid(out_valid),
    .out_ready(out_ready), .out_coef(out_coef), .out_exp(out_exp),
    .term_count(term_count), .status(status), .last(last)
  );

  // Output side: random stalls, check every accepted word.
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready)
        board.check_word('{out_coef, out_exp, term_count, status, last});
      out_ready <= ($urandom_range(99) >= recv_stall);
    end
  end

  // Watchdog: generous against 433 words of worst-case sort plus stalls.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 900000) begin
      $display("FAIL sparse_polynomial_term_table");
      $finish;
    end
  end

  // Present one word, hold it until accepted. Valid drops only for idle
  // cycles, so back-to-back words keep it high.
  task automatic push_word(logic [2:0] op, logic [31:0] c, logic [15:0] e);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 0;
      @(posedge clk);
    end
    cmd <= op;
    term_coef <= c;
    term_exp <= e;
    in_valid <= 1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    board.note_word(op, c, e);
  endtask

  function automatic logic [31:0] pick_coef();
    case ($urandom_range(5))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 0;
      3: return $urandom;
      default: return 32'($signed($urandom_range(8)) - 4);
    endcase
  endfunction

  // Exponents from a small pool so merges and cancels happen often.
  function automatic logic [15:0] pick_exp();
    case ($urandom_range(4))
      0: return $urandom;
      1: return 16'hFFFF;
      default: return 16'($urandom_range(20));
    endcase
  endfunction

  task automatic random_words(int n);
    int r;
    logic [2:0] op;
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(99);
      if (r < 30) op = CMD_ADD;
      else if (r < 45) op = CMD_SUB;
      else if (r < 55) op = CMD_MUL;
      else if (r < 70) op = CMD_QUERY;
      else if (r < 74) op = CMD_CLEAR;
      else if (r < 82) op = CMD_SORT;
      else if (r < 97) op = CMD_DUMP;
      else op = CMD_NONE;
      if (op == CMD_MUL)
        push_word(op, ($urandom_range(9) == 0) ? 0 : pick_coef(),
                  ($urandom_range(5) == 0) ? 16'($urandom) : 16'($urandom_range(3)));
      else
        push_word(op, pick_coef(), pick_exp());
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // Directed: empty dump, zero new term, cancel, full table, overflow, etc.
    push_word(CMD_DUMP, 0, 16'h1234);
    push_word(CMD_ADD, 0, 5);
    push_word(CMD_ADD, 32'h8000_0000, 16'hFFFF);
    push_word(CMD_SUB, 32'h8000_0000, 0);
    push_word(CMD_ADD, 32'h7FFF_FFFF, 3);
    push_word(CMD_SUB, 32'h7FFF_FFFF, 3);
    push_word(CMD_QUERY, 0, 16'hFFFF);
    push_word(CMD_QUERY, 0, 3);
    push_word(CMD_MUL, 2, 1);
    push_word(CMD_ADD, 1, 1);
    push_word(CMD_MUL, 2, 0);
    for (int i = 0; i < 17; i++) push_word(CMD_ADD, -1, 16'(i + 2));
    push_word(CMD_SORT, 0, 0);
    push_word(CMD_DUMP, 32'hFFFF_FFFF, 16'hFFFF);
    push_word(CMD_MUL, 0, 0);
    push_word(CMD_NONE, 32'hFFFF_FFFF, 16'hA5A5);
    push_word(CMD_CLEAR, 0, 0);
    // Random phases: none, sender idle, receiver stall, both.
    random_words(100);
    send_idle = 62;
    random_words(100);
    send_idle = 0;
    recv_stall = 62;
    random_words(100);
    send_idle = 30;
    recv_stall = 30;
    random_words(100);
    in_valid <= 0;
    while (board.owed.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (board.errors == 0 && board.owed.size() == 0)
      $display("PASS sparse_polynomial_term_table");
    else
      $display("FAIL sparse_polynomial_term_table");
    $finish;
  end
endmodule

FILE: sparse_polynomial_term_table.f
hdl/sptt_pkg.sv
hdl/sparse_polynomial_term_table.sv
bench/testbench.sv
